// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lph_pkg.sv =====
// Shared types, codes and constants of the linear-probe hash map.
// Depends on nothing.
package lph_pkg;

   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_KEY_BYTES   = 8;
   localparam int DEF_VALUE_BYTES = 8;

   localparam int DATA_W  = 64;
   localparam int ENTRY_W = 9;

   localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;

   // request actions
   localparam logic [1:0] ACT_GET  = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_DEL  = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_INS  = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [DATA_W-1:0]  read_value;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PRD,
      ST_PCHK,
      ST_DRD,
      ST_DCHK,
      ST_FIN
   } state_type;

endpackage

// ===== design/lph_hash.sv =====
// FNV-1a 64-bit hash unit, one key byte per cycle.
// Depends on lph_pkg.
module lph_hash import lph_pkg::*; #(
   parameter int KEY_BYTES = DEF_KEY_BYTES,
   parameter int IDX_W     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] key,
   output logic              done,
   output logic [IDX_W-1:0]  home
);

   localparam int CW = $clog2(KEY_BYTES + 1);

   logic [63:0]   h_ff, h_in;
   logic [63:0]   k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [63:0]   x;
   logic [63:0]   mixed;

   // xor in the low byte, then multiply by the prime 2^40 + 0x1B3 as shifts
   assign x     = h_ff ^ {56'd0, k_ff[7:0]};
   assign mixed = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;

   always_comb begin
      h_in    = h_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         h_in    = FNV_OFFSET;
         k_in    = key;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         h_in   = mixed;
         k_in   = k_ff >> 8;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(KEY_BYTES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign home = h_ff[IDX_W-1:0];

endmodule

// ===== design/lph_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on lph_pkg.
module lph_mem import lph_pkg::*; #(
   parameter int ADDR_W = 8,
   parameter int WORD_W = 136
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [2**ADDR_W];
   logic [WORD_W-1:0] rd_ff;

   // write the slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ===== design/linear_probe_hash_map.sv =====
// Channel  Ports          Payload   Direction
// request  req_valid/rdy  req_type  in   (get, set, delete)
// result   rsp_valid/rdy  rsp_type  out  (one per request)
//
// A request is accepted in an idle cycle, then is hashed; each probed slot takes a memory
// read, then a compare, and the result is then posted.
// A delete adds a read and a check for each slot walked in the backward-shift repair.
// The unused action skips hashing and probing and goes straight to the post.
// The single read port of the slot memory sets the probe pace.
// Reset clears the occupancy bits and the count at once; no sweep is needed.
// A waiting result stalls only the next post, not the next request's work.
// Depends on lph_pkg, lph_hash, lph_mem.
module linear_probe_hash_map import lph_pkg::*; #(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int KEY_BYTES   = DEF_KEY_BYTES,
   parameter int VALUE_BYTES = DEF_VALUE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int LIM_W   = CNT_W + 2;
   localparam int WORD_W  = IDX_W + 2 * DATA_W;
   localparam logic [LIM_W-1:0] LOAD_LIMIT = LIM_W'(3 * CAPACITY);
   localparam logic [DATA_W-1:0] KEY_MASK =
      (KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);
   localparam logic [DATA_W-1:0] VAL_MASK =
      (VALUE_BYTES >= 8) ? '1 : ((64'd1 << (8 * VALUE_BYTES)) - 64'd1);

   state_type         state_ff, state_in;
   logic [1:0]        act_ff, act_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  hole_ff, hole_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] occ_ff, occ_in;
   logic [1:0]        status_ff, status_in;
   logic [DATA_W-1:0] rdv_ff, rdv_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              hash_start;
   logic              hash_done;
   logic [IDX_W-1:0]  hash_home;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [WORD_W-1:0] rd_word;
   logic [IDX_W-1:0]  rd_home;
   logic [DATA_W-1:0] rd_key;
   logic [DATA_W-1:0] rd_val;

   logic occ_i, key_hit, probe_end, full_lim, out_free, move_ok;

   lph_hash #(.KEY_BYTES(KEY_BYTES), .IDX_W(IDX_W)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_in),
      .done  (hash_done),
      .home  (hash_home)
   );

   lph_mem #(.ADDR_W(IDX_W), .WORD_W(WORD_W)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   // split the slot word
   assign rd_home = rd_word[WORD_W-1 -: IDX_W];
   assign rd_key  = rd_word[2*DATA_W-1:DATA_W];
   assign rd_val  = rd_word[DATA_W-1:0];

   assign occ_i     = occ_ff[idx_ff];
   assign key_hit   = (rd_key == key_ff);
   assign probe_end = (n_ff == CNT_W'(CAPACITY - 1));
   assign full_lim  = ({count_ff, 2'b00} >= LOAD_LIMIT);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // entry may move back if the hole lies within its probe distance
   assign move_ok   = (IDX_W'(idx_ff - rd_home) >= IDX_W'(idx_ff - hole_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.action == ACT_NONE) ? ST_FIN : ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_PRD;
            end
         end
         ST_PRD:  state_in = ST_PCHK;
         ST_PCHK: begin
            if (occ_i && !key_hit && !probe_end) begin
               state_in = ST_PRD;
            end else if (occ_i && key_hit && act_ff == ACT_DEL) begin
               state_in = ST_DRD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DRD:  state_in = ST_DCHK;
         ST_DCHK: begin
            state_in = (occ_i && !probe_end) ? ST_DRD : ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      act_in       = act_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      home_in      = home_ff;
      idx_in       = idx_ff;
      hole_in      = hole_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      occ_in       = occ_ff;
      status_in    = status_ff;
      rdv_in       = rdv_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hash_start   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = {home_ff, key_ff, val_ff};
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            key_in = req_data.key & KEY_MASK;
            if (req_valid) begin
               act_in     = req_data.action;
               val_in     = req_data.value & VAL_MASK;
               status_in  = STAT_MISS;
               rdv_in     = '0;
               hash_start = 1'b1;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               home_in = hash_home;
               idx_in  = hash_home;
               n_in    = '0;
            end
         end
         ST_PRD: rd_en = 1'b1;
         ST_PCHK: begin
            if (occ_i && key_hit) begin
               status_in = STAT_OK;
               case (act_ff)
                  ACT_GET: rdv_in = rd_val;
                  ACT_SET: begin
                     wr_en   = 1'b1;
                     wr_data = {rd_home, key_ff, val_ff};
                  end
                  ACT_DEL: begin
                     occ_in[idx_ff] = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                     hole_in = idx_ff;
                     idx_in  = idx_ff + IDX_W'(1);
                     n_in    = '0;
                  end
                  default: status_in = STAT_MISS;
               endcase
            end else if (occ_i && !probe_end) begin
               // advance the probe with wrap
               idx_in = idx_ff + IDX_W'(1);
               n_in   = n_ff + CNT_W'(1);
            end else if (act_ff == ACT_SET) begin
               if (full_lim || occ_i) begin
                  status_in = STAT_FULL;
               end else begin
                  // insert into the first empty slot of the chain
                  status_in      = STAT_INS;
                  wr_en          = 1'b1;
                  occ_in[idx_ff] = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
            end
         end
         ST_DRD: rd_en = 1'b1;
         ST_DCHK: begin
            if (occ_i && !probe_end) begin
               if (move_ok) begin
                  // shift the entry back into the hole
                  wr_en           = 1'b1;
                  wr_addr         = hole_ff;
                  wr_data         = rd_word;
                  occ_in[hole_ff] = 1'b1;
                  occ_in[idx_ff]  = 1'b0;
                  hole_in         = idx_ff;
               end
               idx_in = idx_ff + IDX_W'(1);
               n_in   = n_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_in.status      = status_ff;
               rsp_in.read_value  = rdv_ff;
               rsp_in.entry_count = ENTRY_W'(count_ff);
               rsp_valid_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      home_ff   <= home_in;
      idx_ff    <= idx_in;
      hole_ff   <= hole_in;
      n_ff      <= n_in;
      status_ff <= status_in;
      rdv_ff    <= rdv_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/lph_checker.sv =====
// Port-level checks of the hash map, bound to the top level.
// Depends on lph_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lph_checker import lph_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam int CNT_MAX = (CAPACITY * 3 + 3) / 4;

   // hold a stalled result
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // one request at a time: drop ready after a transfer
   `ASSERT_NXT(a_req_one, clock, reset, req_valid && req_ready, !req_ready, "request accepted back to back")

   // only a successful lookup returns data
   `ASSERT_IMP(a_rdv_zero, clock, reset, rsp_valid && rsp_data.status != STAT_OK, rsp_data.read_value == '0, "read value set on a miss")

   // inserts stop at the load limit
   `ASSERT_IMP(a_cnt_max, clock, reset, rsp_valid, rsp_data.entry_count <= ENTRY_W'(CNT_MAX), "entry count above load limit")

   // a refusal only happens at the load limit
   `ASSERT_IMP(a_full_lim, clock, reset, rsp_valid && rsp_data.status == STAT_FULL, 32'(rsp_data.entry_count) * 4 >= CAPACITY * 3, "set refused below load limit")

endmodule

bind linear_probe_hash_map lph_checker #(.CAPACITY(CAPACITY)) u_lph_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_linear_probe_hash_map.sv =====
// Self-checking testbench of the linear-probe hash map: directed and random requests,
// checked against a behavioral table model with FNV-1a hashing and backward-shift delete.
// Depends on lph_pkg and linear_probe_hash_map.
module tb_linear_probe_hash_map;
   timeunit 1ns;
   timeprecision 1ps;
   import lph_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int WATCH_LIMIT = 20000;
   localparam logic [63:0] FNV_MUL = 64'd1099511628211;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   linear_probe_hash_map u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // table model
   logic [63:0] tbl_key [CAP];
   logic [63:0] tbl_val [CAP];
   bit          tbl_used [CAP];
   int          tbl_count;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   logic [63:0] live_keys[$];
   int  mismatches = 0;
   int  transfers_in = 0, transfers_out = 0;
   bit  stim_done = 0;
   bit  hold_rsp = 0;
   int  n_full = 0, n_ins = 0, n_del = 0;

   function automatic int slot_of(logic [63:0] k);
      logic [63:0] h;
      h = FNV_OFFSET;
      for (int i = 0; i < DEF_KEY_BYTES; i++) begin
         h = (h ^ {56'd0, k[8*i +: 8]}) * FNV_MUL;
      end
      return int'(h % CAP);
   endfunction

   function automatic int locate(logic [63:0] k);
      int s;
      s = slot_of(k);
      for (int n = 0; n < CAP; n++) begin
         if (!tbl_used[s]) return CAP;
         if (tbl_key[s] == k) return s;
         s = (s + 1) % CAP;
      end
      return CAP;
   endfunction

   function automatic void shift_back(int hole);
      int j, h;
      j = (hole + 1) % CAP;
      tbl_used[hole] = 0;
      for (int n = 0; n + 1 < CAP && tbl_used[j]; n++) begin
         h = slot_of(tbl_key[j]);
         if ((j - h + CAP) % CAP >= (j - hole + CAP) % CAP) begin
            tbl_key[hole] = tbl_key[j];
            tbl_val[hole] = tbl_val[j];
            tbl_used[hole] = 1;
            tbl_used[j] = 0;
            hole = j;
         end
         j = (j + 1) % CAP;
      end
   endfunction

   // apply one request to the table model and queue its result
   function automatic void predict_lookup(req_type r);
      rsp_type e;
      int s;
      e = '0;
      e.status = STAT_MISS;
      case (r.action)
         ACT_GET: begin
            s = locate(r.key);
            if (s < CAP) begin
               e.status = STAT_OK;
               e.read_value = tbl_val[s];
            end
         end
         ACT_SET: begin
            s = locate(r.key);
            if (s < CAP) begin
               tbl_val[s] = r.value;
               e.status = STAT_OK;
            end else if (tbl_count * 4 >= CAP * 3) begin
               e.status = STAT_FULL;
               n_full++;
            end else begin
               s = slot_of(r.key);
               while (tbl_used[s]) s = (s + 1) % CAP;
               tbl_key[s] = r.key;
               tbl_val[s] = r.value;
               tbl_used[s] = 1;
               tbl_count++;
               e.status = STAT_INS;
               n_ins++;
            end
         end
         ACT_DEL: begin
            s = locate(r.key);
            if (s < CAP) begin
               shift_back(s);
               tbl_count--;
               e.status = STAT_OK;
               n_del++;
            end
         end
         default: ;
      endcase
      e.entry_count = tbl_count[ENTRY_W-1:0];
      expected_rsps.push_back(e);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH result %0d %s: got %h want %h", transfers_out, what, got, want);
      mismatches++;
   endtask

   // driver: offer queued requests after a random gap
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_lookup(req_data);
            transfers_in++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
               send_gap <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check results, stall at random
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            transfers_out++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected", rsp_data.status, 0);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status)
                  report_mismatch("status", rsp_data.status, e.status);
               if (rsp_data.read_value !== e.read_value)
                  report_mismatch("read_value", rsp_data.read_value, e.read_value);
               if (rsp_data.entry_count !== e.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count, e.entry_count);
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready)
               recv_gap <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
         end
      end
   end

   // watchdog: count cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (stim_done && pending_reqs.size() == 0 && expected_rsps.size() == 0))
         idle_cycles <= 0;
      else if (!hold_rsp)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_rsps.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] a, logic [63:0] k, logic [63:0] v);
      req_type r;
      r.action = a;
      r.key = k;
      r.value = v;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // pick a key: mostly from recently picked ones to hit the chains
   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      if (live_keys.size() > 0 && $urandom_range(0, 2) != 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      k = ($urandom_range(0, 1) != 0) ? {56'd0, 8'($urandom)} : rand64();
      live_keys.push_back(k);
      if (live_keys.size() > 300) void'(live_keys.pop_front());
      return k;
   endfunction

   task automatic wait_drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [1:0] act;
      for (int i = 0; i < CAP; i++) tbl_used[i] = 0;
      tbl_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, unused action, absent delete
      pending_reqs.push_back(make_req(ACT_GET, 64'd0, 64'd0));
      pending_reqs.push_back(make_req(ACT_DEL, 64'd0, 64'd0));
      pending_reqs.push_back(make_req(ACT_SET, 64'd0, '1));
      pending_reqs.push_back(make_req(ACT_SET, '1, 64'd0));
      pending_reqs.push_back(make_req(ACT_GET, 64'd0, 64'd5));
      pending_reqs.push_back(make_req(ACT_GET, '1, '1));
      pending_reqs.push_back(make_req(ACT_SET, '1, 64'h5555_aaaa_5555_aaaa));
      pending_reqs.push_back(make_req(ACT_GET, '1, 64'd0));
      pending_reqs.push_back(make_req(ACT_NONE, '1, '1));
      pending_reqs.push_back(make_req(ACT_NONE, 64'd0, 64'd0));
      pending_reqs.push_back(make_req(ACT_DEL, 64'd0, 64'd0));
      pending_reqs.push_back(make_req(ACT_GET, 64'd0, 64'd0));
      pending_reqs.push_back(make_req(ACT_DEL, '1, 64'd0));
      pending_reqs.push_back(make_req(ACT_DEL, 64'h1234, 64'd0));
      wait_drain();

      // fill past the load limit so full refusals and long chains show up
      for (int i = 0; i < 200; i++)
         pending_reqs.push_back(make_req(ACT_SET, {56'd0, 8'(i)}, rand64()));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(make_req(ACT_GET, {56'd0, 8'(i * 31)}, 64'd0));

      // receiver holds off while requests keep coming
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
      wait_drain();

      // drain half the table, then random mix
      for (int i = 0; i < 200; i += 2)
         pending_reqs.push_back(make_req(ACT_DEL, {56'd0, 8'(i)}, 64'd0));
      for (int i = 0; i < 1500; i++) begin
         case ($urandom_range(0, 19))
            0:              act = ACT_NONE;
            1,2,3,4,5:      act = ACT_GET;
            6,7,8,9,10,11:  act = ACT_DEL;
            default:        act = ACT_SET;
         endcase
         pending_reqs.push_back(make_req(act, pick_key(), rand64()));
         if (i == 750) wait_drain();
      end
      wait_drain();
      stim_done = 1;
      repeat (200) @(posedge clock);

      $display("Sent %0d requests, checked %0d results", transfers_in, transfers_out);
      $display("Inserts %0d, deletes %0d, full refusals %0d", n_ins, n_del, n_full);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+design
design/lph_pkg.sv
design/lph_hash.sv
design/lph_mem.sv
design/linear_probe_hash_map.sv
design/lph_checker.sv
tb/tb_linear_probe_hash_map.sv
